// ===== src/sclt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sclt_pkg: shared types and constants of the sector cache tag controller
// Holds the field widths, the queued request and result types and the engine states.
// ----------------------------------------------------------------------------
package sclt_pkg;

  localparam int SectorWidth = 32;
  localparam int SlotWidth   = 6;
  localparam int StampWidth  = 32;

  localparam logic OpRead  = 1'b0;
  localparam logic OpWrite = 1'b1;

  // request handed from the front part to the engine
  typedef struct packed {
    logic                   is_write;
    logic                   bypass;
    logic [SectorWidth-1:0] sector;
  } req_t;

  // result item
  typedef struct packed {
    logic                   hit;
    logic [SlotWidth-1:0]   slot;
    logic                   fetch_from_disk;
    logic                   write_direct;
    logic                   evict;
    logic [SectorWidth-1:0] evicted_sector;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_VICTIM,
    ST_UPDATE,
    ST_OUT
  } eng_state_t;

endpackage
`default_nettype wire

// ===== src/sector_cache_lru_tags.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sector_cache_lru_tags: fully associative sector cache tag controller
// Looks up sectors, fills free slots, replaces the least recently used slot.
// ----------------------------------------------------------------------------
// Usage: s_axis carries accesses (tdata = opcode, sector). m_axis returns one
// result per access (tdata = hit, slot, fetch_from_disk, write_direct, evict,
// evicted_sector). cache_enable_we/cache_enable_wdata write the enable bit;
// write it only while idle.
// A two-entry queue decouples input acceptance from the tag engine. The
// engine walks all ENTRIES tag/stamp memory slots one per cycle through a
// single read port; a cached access passes through idle, the walk, victim,
// update and output, while a bypassed access goes from idle straight to
// output. One access is worked on at a time.
// Reset clears valid bits, the access counter and enables the cache.
// A stalled m_axis holds the result; the queue keeps accepting until full.
// ----------------------------------------------------------------------------
module sector_cache_lru_tags
  import sclt_pkg::*;
#(
  parameter int ENTRIES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cache_enable_we,
  input  wire logic        cache_enable_wdata,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // [0] opcode, [32:1] sector, rest zero
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata   // [0] hit,[6:1] slot,[7] fetch,[8] wdir,
                                          // [9] evict,[41:10] evicted_sector
);

  logic cache_enable;
  logic req_valid, req_ready;
  req_t req;
  res_t res;

  always_ff @(posedge clk) begin
    if (rst) cache_enable <= 1'b1;
    else if (cache_enable_we) cache_enable <= cache_enable_wdata;
  end

  sclt_front u_front (
    .clk, .rst, .cache_enable,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_is_write(s_axis_tdata[0]), .in_sector(s_axis_tdata[32:1]),
    .req_valid, .req_ready, .req
  );

  sclt_engine #(.ENTRIES(ENTRIES)) u_engine (
    .clk, .rst, .req_valid, .req_ready, .req,
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res
  );

  assign m_axis_tdata = {6'd0, res.evicted_sector, res.evict, res.write_direct,
                         res.fetch_from_disk, res.slot, res.hit};

  // a result never both writes direct and hits
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[8] && m_axis_tdata[0])) else $error("wdir with hit");
  // evict excludes hit
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[9] && m_axis_tdata[0])) else $error("evict on hit");
  // stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata)) else $error("result moved");

endmodule
`default_nettype wire

// ===== src/sclt_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sclt_front: input stage and request queue
// Takes input items, tags them with the bypass decision and queues them.
// ----------------------------------------------------------------------------
module sclt_front
  import sclt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cache_enable,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_is_write,
  input  wire logic [31:0] in_sector,
  output logic             req_valid,
  input  wire logic        req_ready,
  output req_t             req
);

  localparam int Depth = 2;

  req_t       q [Depth];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push, pop;

  assign in_ready  = (count != 2'(Depth));
  assign push      = in_valid && in_ready;
  assign req_valid = (count != 2'd0);
  assign pop       = req_valid && req_ready;
  assign req       = q[rd_ptr];

  // store classified items
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= '{is_write: in_is_write, bypass: ~cache_enable, sector: in_sector};
    end
  end

  // advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

// ===== src/sclt_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sclt_engine: tag walk and replacement engine
// Walks tag/stamp memories one slot a cycle, updates and replies, or bypasses.
// ----------------------------------------------------------------------------
module sclt_engine
  import sclt_pkg::*;
#(
  parameter int ENTRIES = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  req_t      req,
  output logic      res_valid,
  input  wire logic res_ready,
  output res_t      res
);

  localparam int IdxW = $clog2(ENTRIES);

  logic [SectorWidth-1:0] tag_mem   [ENTRIES];
  logic [StampWidth-1:0]  stamp_mem [ENTRIES];
  logic [ENTRIES-1:0]     valid_bits;

  eng_state_t state, state_next;
  req_t       cur;
  logic [IdxW:0]   idx;
  logic [IdxW-1:0] ridx;
  logic            rd_live;
  logic [IdxW-1:0] rd_idx_q;
  logic [SectorWidth-1:0] tag_q;
  logic [StampWidth-1:0]  stamp_q;
  logic                   found, free_found, best_set;
  logic [IdxW-1:0]        hit_slot, free_slot, best;
  logic [StampWidth-1:0]  best_stamp;
  logic [SectorWidth-1:0] best_tag;
  logic [StampWidth-1:0]  access_counter;
  logic [IdxW-1:0]        slot_sel;
  logic                   scan_done;

  assign ridx      = idx[IdxW-1:0];
  assign scan_done = (idx == (IdxW+1)'(ENTRIES)) && !rd_live;
  assign req_ready = (state == ST_IDLE);
  assign res_valid = (state == ST_OUT);
  assign slot_sel  = found ? hit_slot : (free_found ? free_slot : best);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (req_valid) state_next = req.bypass ? ST_OUT : ST_SCAN;
      ST_SCAN:   if (scan_done) state_next = ST_VICTIM;
      ST_VICTIM: state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_OUT;
      ST_OUT:    if (res_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // memory reads, one slot a cycle
  always_ff @(posedge clk) begin
    tag_q    <= tag_mem[ridx];
    stamp_q  <= stamp_mem[ridx];
    rd_idx_q <= ridx;
  end

  // memory writes on update
  always_ff @(posedge clk) begin
    if (state == ST_UPDATE) begin
      tag_mem[slot_sel]   <= cur.sector;
      stamp_mem[slot_sel] <= access_counter;
    end
  end

  // walk and compare
  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      rd_live    <= 1'b0;
      valid_bits <= '0;
      access_counter <= '0;
      found <= 1'b0;
      free_found <= 1'b0;
      best_set <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (req_valid) begin
            cur        <= req;
            idx        <= '0;
            rd_live    <= 1'b0;
            found      <= 1'b0;
            free_found <= 1'b0;
            best_set   <= 1'b0;
            best       <= '0;
            best_stamp <= '0;
          end
        end
        ST_SCAN: begin
          if (idx != (IdxW+1)'(ENTRIES)) begin
            idx     <= idx + 1'b1;
            rd_live <= 1'b1;
          end else begin
            rd_live <= 1'b0;
          end
          if (rd_live) begin
            if (valid_bits[rd_idx_q]) begin
              if (!found && tag_q == cur.sector) begin
                found    <= 1'b1;
                hit_slot <= rd_idx_q;
              end
              if (!best_set || stamp_q < best_stamp) begin
                best_set   <= 1'b1;
                best       <= rd_idx_q;
                best_stamp <= stamp_q;
                best_tag   <= tag_q;
              end
            end else if (!free_found) begin
              free_found <= 1'b1;
              free_slot  <= rd_idx_q;
            end
          end
        end
        ST_VICTIM: begin
          access_counter <= access_counter + 1'b1;
        end
        ST_UPDATE: begin
          valid_bits[slot_sel] <= 1'b1;
        end
        ST_OUT: ;
        default: ;
      endcase
    end
  end

  // build result; victim tag kept from the walk
  always_comb begin
    res = '0;
    if (cur.bypass) begin
      res.fetch_from_disk = ~cur.is_write;
      res.write_direct    = cur.is_write;
    end else begin
      res.hit             = found;
      res.slot            = SlotWidth'({{(SlotWidth+1){1'b0}}, slot_sel});
      res.fetch_from_disk = !found && !cur.is_write;
      res.evict           = !found && !free_found;
      res.evicted_sector  = res.evict ? best_tag : '0;
    end
  end

endmodule
`default_nettype wire
